// ===== rtl/wsq_pkg.sv =====
// Shared types and constants of the waypoint sequencer.
`default_nettype none

package wsq_pkg;

  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int TOL_W         = 15;
  localparam int TIMEOUT_W     = 16;
  localparam int MODE_W        = 3;
  localparam int SLOT_W        = 6;
  localparam int TOTAL_W       = 7;
  localparam int RAW_SLOTS     = 8;
  localparam int RAW_SEL_W     = 3;
  localparam int WP_INDEX_W    = 6;
  localparam int JOINT_INDEX_W = 3;
  localparam int STATUS_W      = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [TOL_W-1:0]     TOL_RESET     = 15'd410;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REAL_ORDER = 2'd2;

  // Raw slot that feeds each joint when the reordered mapping is selected.
  localparam logic [RAW_SEL_W-1:0] RAW_MAP [RAW_SLOTS] = '{
    3'd7, 3'd5, 3'd6, 3'd3, 3'd4, 3'd2, 3'd0, 3'd1
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 3'd0,
    MODE_START   = 3'd1,
    MODE_SAMPLE  = 3'd2,
    MODE_TICK    = 3'd3,
    MODE_PREEMPT = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HOLDING   = 2'd0,
    ST_ISSUED    = 2'd1,
    ST_ABORTED   = 2'd2,
    ST_SUCCEEDED = 2'd3
  } status_e;

  typedef struct packed {
    status_e                 status;
    logic [WP_INDEX_W-1:0]   index;
    logic                    blank;
  } job_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/wsq_front.sv =====
// Front end: item intake, waypoint table, goal state and per-sample decision.
`default_nettype none

module wsq_front #(
  parameter int MAX_POINTS = 64,
  parameter int JOINTS     = 6,
  parameter int POS_WIDTH  = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [wsq_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire  [wsq_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [wsq_pkg::MODE_W-1:0]           mode_i,
  input  wire  [wsq_pkg::SLOT_W-1:0]           slot_i,
  input  wire  [wsq_pkg::TOTAL_W-1:0]          point_total_i,
  input  wire  [wsq_pkg::RAW_SLOTS*POS_WIDTH-1:0] raw_i,
  input  wire                                  queue_ready_i,
  output logic                                 push_o,
  output wsq_pkg::job_ctrl_t                   ctrl_o,
  output logic [JOINTS*POS_WIDTH-1:0]          desired_o,
  output logic [JOINTS*POS_WIDTH-1:0]          actual_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int SW = (AW > wsq_pkg::SLOT_W) ? AW : wsq_pkg::SLOT_W;
  localparam int XW = (NW > wsq_pkg::WP_INDEX_W) ? NW : wsq_pkg::WP_INDEX_W;
  localparam int CW = (POS_WIDTH > wsq_pkg::TOL_W) ? POS_WIDTH + 2 : wsq_pkg::TOL_W + 2;
  localparam int RW = JOINTS * POS_WIDTH;

  logic [wsq_pkg::TOL_W-1:0]     tolerance_q;
  logic [wsq_pkg::TIMEOUT_W-1:0] timeout_q;
  logic                          real_order_q;
  logic [NW-1:0]                 point_count_q;
  logic [NW-1:0]                 next_point_q;
  logic                          active_q;
  logic [wsq_pkg::TIMEOUT_W-1:0] elapsed_q;
  logic                          s1_valid_q;
  logic [RW-1:0]                 row_prev_q;
  logic [RW-1:0]                 row_next_q;
  logic [RW-1:0]                 actual_q;
  logic [RW-1:0]                 store_mem [MAX_POINTS];

  logic          in_accept;
  logic          is_load;
  logic          is_start;
  logic          is_sample;
  logic          is_tick;
  logic          is_preempt;
  logic          load_wr;
  logic          samp_go;
  logic [SW-1:0] slot_x;
  logic [NW-1:0] start_count;
  logic [NW-1:0] prev_point;
  logic [RW-1:0] actual_sel;
  logic          done;
  logic          in_tol;
  logic          ok_issue;
  logic          timed_out;
  logic [NW-1:0] out_idx;
  logic [XW-1:0] out_idx_x;

  assign in_stall_o = s1_valid_q || !queue_ready_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    is_load    = 1'b0;
    is_start   = 1'b0;
    is_sample  = 1'b0;
    is_tick    = 1'b0;
    is_preempt = 1'b0;
    unique case (wsq_pkg::mode_e'(mode_i))
      wsq_pkg::MODE_LOAD:    is_load    = 1'b1;
      wsq_pkg::MODE_START:   is_start   = 1'b1;
      wsq_pkg::MODE_SAMPLE:  is_sample  = 1'b1;
      wsq_pkg::MODE_TICK:    is_tick    = 1'b1;
      wsq_pkg::MODE_PREEMPT: is_preempt = 1'b1;
      default: ;
    endcase
  end

  assign slot_x      = SW'(slot_i);
  assign load_wr     = in_accept && is_load && (32'(slot_i) < 32'(MAX_POINTS));
  assign samp_go     = in_accept && is_sample && active_q;
  assign start_count = (32'(point_total_i) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                              : NW'(point_total_i);
  assign prev_point  = next_point_q - NW'(1);

  always_comb begin
    logic [wsq_pkg::RAW_SEL_W-1:0] src;
    src        = '0;
    actual_sel = '0;
    for (int j = 0; j < JOINTS; j++) begin
      src = real_order_q ? wsq_pkg::RAW_MAP[j] : wsq_pkg::RAW_SEL_W'(j);
      actual_sel[j*POS_WIDTH +: POS_WIDTH] = raw_i[32'(src)*POS_WIDTH +: POS_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      store_mem[slot_x[AW-1:0]] <= raw_i[RW-1:0];
    end
    if (samp_go) begin
      row_prev_q <= store_mem[prev_point[AW-1:0]];
      row_next_q <= store_mem[next_point_q[AW-1:0]];
      actual_q   <= actual_sel;
    end
  end

  always_comb begin
    logic signed [CW-1:0] diff;
    logic signed [CW-1:0] tol_s;
    tol_s  = signed'(CW'(tolerance_q));
    diff   = '0;
    in_tol = 1'b1;
    for (int j = 0; j < JOINTS; j++) begin
      diff = CW'(signed'(actual_q[j*POS_WIDTH +: POS_WIDTH]))
           - CW'(signed'(row_prev_q[j*POS_WIDTH +: POS_WIDTH]));
      if (diff > tol_s || diff < -tol_s) begin
        in_tol = 1'b0;
      end
    end
  end

  assign done      = next_point_q >= point_count_q;
  assign ok_issue  = (next_point_q == '0) || in_tol;
  assign timed_out = elapsed_q > timeout_q;

  always_comb begin
    ctrl_o.blank = 1'b0;
    out_idx      = prev_point;
    desired_o    = row_prev_q;
    if (done) begin
      ctrl_o.status = wsq_pkg::ST_SUCCEEDED;
      ctrl_o.blank  = (point_count_q == '0);
    end else if (ok_issue) begin
      ctrl_o.status = wsq_pkg::ST_ISSUED;
      out_idx       = next_point_q;
      desired_o     = row_next_q;
    end else if (timed_out) begin
      ctrl_o.status = wsq_pkg::ST_ABORTED;
    end else begin
      ctrl_o.status = wsq_pkg::ST_HOLDING;
    end
    out_idx_x    = XW'(out_idx);
    ctrl_o.index = out_idx_x[wsq_pkg::WP_INDEX_W-1:0];
  end

  assign push_o   = s1_valid_q;
  assign actual_o = actual_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q   <= wsq_pkg::TOL_RESET;
      timeout_q     <= wsq_pkg::TIMEOUT_RESET;
      real_order_q  <= 1'b0;
      point_count_q <= '0;
      next_point_q  <= '0;
      active_q      <= 1'b0;
      elapsed_q     <= '0;
      s1_valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= samp_go;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          wsq_pkg::CFG_TOLERANCE:  tolerance_q  <= cfg_wdata_i[wsq_pkg::TOL_W-1:0];
          wsq_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_wdata_i[wsq_pkg::TIMEOUT_W-1:0];
          wsq_pkg::CFG_REAL_ORDER: real_order_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_accept) begin
        if (is_start) begin
          point_count_q <= start_count;
          next_point_q  <= '0;
          elapsed_q     <= '0;
          active_q      <= 1'b1;
        end
        if (is_tick && (elapsed_q != '1)) begin
          elapsed_q <= elapsed_q + wsq_pkg::TIMEOUT_W'(1);
        end
        if (is_preempt) begin
          active_q <= 1'b0;
        end
      end
      if (s1_valid_q) begin
        if (done) begin
          active_q <= 1'b0;
        end else if (ok_issue) begin
          elapsed_q    <= '0;
          next_point_q <= next_point_q + NW'(1);
        end else if (timed_out) begin
          active_q <= 1'b0;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> queue_ready_i)
    else $error("decided sample found the queue full");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_point_q <= point_count_q)
    else $error("next waypoint passed the point count");

  a_single_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> !s1_valid_q)
    else $error("two sample decisions in consecutive cycles");
`endif

endmodule

`default_nettype wire

// ===== rtl/wsq_fifo.sv =====
// Short job queue between the front end and the result serializer.
`default_nettype none

module wsq_fifo #(
  parameter int WIDTH = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  wire              pop_i
);

  localparam int DEPTH = wsq_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CNTW-1:0]  count_q;

  assign ready_o = count_q != CNTW'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNTW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNTW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/wsq_back.sv =====
// Back end: turns one decided sample into per-joint result words.
`default_nettype none

module wsq_back #(
  parameter int JOINTS    = 6,
  parameter int POS_WIDTH = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    head_valid_i,
  input  wsq_pkg::job_ctrl_t                     head_ctrl_i,
  input  wire  [JOINTS*POS_WIDTH-1:0]            head_desired_i,
  input  wire  [JOINTS*POS_WIDTH-1:0]            head_actual_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic [wsq_pkg::STATUS_W-1:0]           status_o,
  output logic [wsq_pkg::WP_INDEX_W-1:0]         waypoint_index_o,
  output logic [wsq_pkg::JOINT_INDEX_W-1:0]      joint_index_o,
  output logic signed [POS_WIDTH-1:0]            desired_position_o,
  output logic signed [POS_WIDTH:0]              position_error_o,
  output logic                                   last_o
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int EW = POS_WIDTH + 1;

  logic                 out_valid_q;
  logic [JW-1:0]        joint_q;
  wsq_pkg::status_e     status_q;
  logic [wsq_pkg::WP_INDEX_W-1:0]    index_q;
  logic [wsq_pkg::JOINT_INDEX_W-1:0] joint_out_q;
  logic signed [POS_WIDTH-1:0]       desired_q;
  logic signed [EW-1:0]              error_q;
  logic                              last_q;

  logic                        advance;
  logic                        last_joint;
  logic signed [POS_WIDTH-1:0] des;
  logic signed [POS_WIDTH-1:0] act;
  logic signed [EW-1:0]        err;

  assign advance    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last_joint = joint_q == JW'(JOINTS - 1);
  assign pop_o      = advance && last_joint;

  assign des = signed'(head_desired_i[32'(joint_q)*POS_WIDTH +: POS_WIDTH]);
  assign act = signed'(head_actual_i[32'(joint_q)*POS_WIDTH +: POS_WIDTH]);
  assign err = EW'(des) - EW'(act);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      joint_q     <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      joint_q     <= last_joint ? '0 : joint_q + JW'(1);
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q    <= head_ctrl_i.status;
      index_q     <= head_ctrl_i.blank ? '0 : head_ctrl_i.index;
      joint_out_q <= wsq_pkg::JOINT_INDEX_W'(joint_q);
      desired_q   <= head_ctrl_i.blank ? '0 : des;
      error_q     <= head_ctrl_i.blank ? '0 : err;
      last_q      <= last_joint;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign waypoint_index_o   = index_q;
  assign joint_index_o      = joint_out_q;
  assign desired_position_o = desired_q;
  assign position_error_o   = error_q;
  assign last_o             = last_q;

endmodule

`default_nettype wire

// ===== rtl/waypoint_sequencer_with_tolerance_top.sv =====
// Top level of the waypoint sequencer with per-joint tolerance and timeout.
//
// Items enter on the input channel (in_valid_i / in_stall_o) and result words
// leave on the output channel (out_valid_o / out_stall_i). Loads, starts,
// ticks and preempts produce no words. A joint sample taken while a goal is
// active produces JOINTS words, one per joint, with last_o set on the final
// one. The first word passes the sample registers, the queue and the output
// register in turn, and the serializer sends one word per cycle while the
// receiver does not stall. In the cycle after a sample is accepted the
// intake stalls while the tolerance check and the waypoint choice are made
// on the table rows read. A two-entry queue holds decided samples, so the
// intake keeps taking items while the receiver stalls, until that queue
// is full.
// Reset makes the block idle, empties the queue and restores the tolerance,
// timeout and joint order registers; the waypoint table is not cleared.
// Configuration writes on cfg_we_i take effect at the next clock edge.
`default_nettype none

module waypoint_sequencer_with_tolerance_top #(
  parameter int MAX_POINTS = 64,
  parameter int JOINTS     = 6,
  parameter int POS_WIDTH  = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [wsq_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire  [wsq_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [wsq_pkg::MODE_W-1:0]         mode_i,
  input  wire  [wsq_pkg::SLOT_W-1:0]         slot_i,
  input  wire  [wsq_pkg::TOTAL_W-1:0]        point_total_i,
  input  wire  signed [POS_WIDTH-1:0]        pos_0_i,
  input  wire  signed [POS_WIDTH-1:0]        pos_1_i,
  input  wire  signed [POS_WIDTH-1:0]        pos_2_i,
  input  wire  signed [POS_WIDTH-1:0]        pos_3_i,
  input  wire  signed [POS_WIDTH-1:0]        pos_4_i,
  input  wire  signed [POS_WIDTH-1:0]        pos_5_i,
  input  wire  signed [POS_WIDTH-1:0]        pos_6_i,
  input  wire  signed [POS_WIDTH-1:0]        pos_7_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [wsq_pkg::STATUS_W-1:0]       status_o,
  output logic [wsq_pkg::WP_INDEX_W-1:0]     waypoint_index_o,
  output logic [wsq_pkg::JOINT_INDEX_W-1:0]  joint_index_o,
  output logic signed [POS_WIDTH-1:0]        desired_position_o,
  output logic signed [POS_WIDTH:0]          position_error_o,
  output logic                               last_o
);

  localparam int RW = JOINTS * POS_WIDTH;
  localparam int CTRLW = $bits(wsq_pkg::job_ctrl_t);
  localparam int QW = CTRLW + 2 * RW;

  logic [wsq_pkg::RAW_SLOTS*POS_WIDTH-1:0] raw;
  logic               queue_ready;
  logic               push;
  wsq_pkg::job_ctrl_t push_ctrl;
  logic [RW-1:0]      push_desired;
  logic [RW-1:0]      push_actual;
  logic               head_valid;
  logic [QW-1:0]      head_data;
  wsq_pkg::job_ctrl_t head_ctrl;
  logic [RW-1:0]      head_desired;
  logic [RW-1:0]      head_actual;
  logic               pop;

  assign raw = {pos_7_i, pos_6_i, pos_5_i, pos_4_i, pos_3_i, pos_2_i, pos_1_i, pos_0_i};

  wsq_front #(
    .MAX_POINTS (MAX_POINTS),
    .JOINTS     (JOINTS),
    .POS_WIDTH  (POS_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .slot_i        (slot_i),
    .point_total_i (point_total_i),
    .raw_i         (raw),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .ctrl_o        (push_ctrl),
    .desired_o     (push_desired),
    .actual_o      (push_actual)
  );

  wsq_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_ctrl, push_desired, push_actual}),
    .ready_o (queue_ready),
    .valid_o (head_valid),
    .data_o  (head_data),
    .pop_i   (pop)
  );

  assign head_ctrl    = wsq_pkg::job_ctrl_t'(head_data[QW-1 -: CTRLW]);
  assign head_desired = head_data[2*RW-1 -: RW];
  assign head_actual  = head_data[RW-1:0];

  wsq_back #(
    .JOINTS    (JOINTS),
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (head_valid),
    .head_ctrl_i        (head_ctrl),
    .head_desired_i     (head_desired),
    .head_actual_i      (head_actual),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .waypoint_index_o   (waypoint_index_o),
    .joint_index_o      (joint_index_o),
    .desired_position_o (desired_position_o),
    .position_error_o   (position_error_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire
